[src/order_statistic_multiset_assert.svh]
// Assertion macros for the order statistic multiset.
// Define NO_ASSERTIONS to compile them out.
`ifndef ORDER_STATISTIC_MULTISET_ASSERT_SVH
`define ORDER_STATISTIC_MULTISET_ASSERT_SVH

`ifndef NO_ASSERTIONS

`define OSM_ASSERT(label, expr) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) \
        else $error("order_statistic_multiset: invariant violated");

`define OSM_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("order_statistic_multiset: sequence violated");

`else

`define OSM_ASSERT(label, expr)
`define OSM_ASSERT_NEXT(label, ante, cons)

`endif

`endif

[src/osm_pkg.sv]
`default_nettype none

package osm_pkg;

    localparam int CAPACITY = 1024;
    localparam int DATA_W   = 32;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int GRP      = 32;
    localparam int NGRP     = (CAPACITY + GRP - 1) / GRP;

    typedef enum logic [2:0] {
        OP_INS  = 3'd0,
        OP_DEL  = 3'd1,
        OP_RANK = 3'd2,
        OP_SEL  = 3'd3,
        OP_PRED = 3'd4,
        OP_SUCC = 3'd5
    } t_op;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_MISSING = 2'd1,
        ST_FULL    = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CMP,
        S_RED1,
        S_RED2,
        S_FIN
    } t_state;

    typedef struct packed {
        logic lt;
        logic le;
        logic gt;
    } t_flags;

    typedef struct packed {
        logic                     cmp_en;
        logic                     ins_en;
        logic                     del_en;
        t_op                      op;
        logic signed [DATA_W-1:0] value;
        logic [IDX_W-1:0]         sel_idx;
        logic [CNT_W-1:0]         count;
    } t_bcast;

    typedef struct packed {
        logic              hit;
        logic [IDX_W-1:0]  idx;
        logic [DATA_W-1:0] value;
    } t_hit;

endpackage

`default_nettype wire

[src/osm_cell.sv]
`default_nettype none

module osm_cell
    import osm_pkg::*;
(
    input  wire logic                     i_clk,
    input  wire logic [IDX_W-1:0]         i_index,
    input  wire t_bcast                   i_bc,
    input  wire t_flags                   i_prev,
    input  wire t_flags                   i_next,
    input  wire logic signed [DATA_W-1:0] i_val_prev,
    input  wire logic signed [DATA_W-1:0] i_val_next,
    output t_flags                        o_flags,
    output logic signed [DATA_W-1:0]      o_value,
    output t_hit                          o_hit
);

    logic signed [DATA_W-1:0] r_value;
    t_flags                   r_flags;
    t_flags                   w_cmp;
    logic                     w_occ;
    logic                     w_hit;

    always_comb begin
        w_occ    = CNT_W'(i_index) < i_bc.count;
        w_cmp.lt = w_occ && (r_value < i_bc.value);
        w_cmp.le = w_occ && (r_value <= i_bc.value);
        w_cmp.gt = w_occ && (r_value > i_bc.value);
    end

    always_ff @(posedge i_clk) begin
        if (i_bc.cmp_en) begin
            r_flags <= w_cmp;
        end
        if (i_bc.ins_en && !r_flags.le) begin
            r_value <= i_prev.le ? i_bc.value : i_val_prev;
        end else if (i_bc.del_en && !r_flags.lt) begin
            r_value <= i_val_next;
        end
    end

    always_comb begin
        case (i_bc.op)
            OP_DEL:  w_hit = i_prev.lt && !r_flags.lt && r_flags.le;
            OP_RANK: w_hit = i_prev.lt && !r_flags.lt;
            OP_SEL:  w_hit = (i_index == i_bc.sel_idx);
            OP_PRED: w_hit = r_flags.lt && !i_next.lt;
            OP_SUCC: w_hit = r_flags.gt && !i_prev.gt;
            default: w_hit = 1'b0;
        endcase
        o_hit.hit   = w_hit;
        o_hit.idx   = w_hit ? i_index : '0;
        o_hit.value = w_hit ? r_value : '0;
    end

    assign o_flags = r_flags;
    assign o_value = r_value;

endmodule

`default_nettype wire

[src/osm_reduce.sv]
`default_nettype none

module osm_reduce
    import osm_pkg::*;
(
    input  wire logic i_clk,
    input  wire t_hit i_hits [CAPACITY],
    output t_hit      o_red
);

    t_hit r_grp [NGRP];
    t_hit n_grp [NGRP];
    t_hit r_red;
    t_hit n_red;

    always_comb begin
        for (int g = 0; g < NGRP; g++) begin
            n_grp[g] = '0;
            for (int j = 0; j < GRP; j++) begin
                if (g * GRP + j < CAPACITY) begin
                    n_grp[g] = t_hit'(n_grp[g] | i_hits[g * GRP + j]);
                end
            end
        end
    end

    always_comb begin
        n_red = '0;
        for (int g = 0; g < NGRP; g++) begin
            n_red = t_hit'(n_red | r_grp[g]);
        end
    end

    always_ff @(posedge i_clk) begin
        r_grp <= n_grp;
        r_red <= n_red;
    end

    assign o_red = r_red;

endmodule

`default_nettype wire

[src/order_statistic_multiset.sv]
// Channel   Handshake            Fields
// command   start / busy         i_operation, i_operand_value
// result    o_valid (strobe)     o_result_value, o_status
//
// A transaction is taken at a rising edge with start high and busy low.
// Each passes through a compare across the cell row (S_CMP), two levels of
// the registered OR tree that gathers the selected cell (S_RED1, S_RED2), and a
// final state (S_FIN) that forms the result and shifts the row on insert or delete.
// A new transaction can already be taken in that final state, where busy is low.
// The result strobe lasts one cycle; the receiver cannot stall it.
// Reset is synchronous and empties the store; no clearing pass is needed.
`default_nettype none

`include "order_statistic_multiset_assert.svh"

module order_statistic_multiset
    import osm_pkg::*;
(
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     start,
    output logic                          busy,
    input  wire logic [2:0]               i_operation,
    input  wire logic signed [DATA_W-1:0] i_operand_value,
    output logic                          o_valid,
    output logic signed [DATA_W-1:0]      o_result_value,
    output logic [1:0]                    o_status
);

    t_state                   r_state;
    t_state                   n_state;
    t_op                      r_op;
    t_op                      n_op;
    logic signed [DATA_W-1:0] r_value;
    logic signed [DATA_W-1:0] n_value;
    logic [CNT_W-1:0]         r_count;
    logic [CNT_W-1:0]         n_count;
    logic                     r_valid;
    logic                     n_valid;
    logic signed [DATA_W-1:0] r_result;
    logic signed [DATA_W-1:0] n_result;
    t_status                  r_status;
    t_status                  n_status;
    t_bcast                   w_bc;
    t_hit                     w_red;
    logic [CNT_W-1:0]         w_pos;
    logic                     w_accept;

    t_flags                   w_flags [CAPACITY];
    logic signed [DATA_W-1:0] w_val   [CAPACITY];
    t_hit                     w_hits  [CAPACITY];

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
            t_flags                   w_prev;
            t_flags                   w_next;
            logic signed [DATA_W-1:0] w_vprev;
            logic signed [DATA_W-1:0] w_vnext;

            if (gi == 0) begin : g_first
                assign w_prev  = '{lt: 1'b1, le: 1'b1, gt: 1'b0};
                assign w_vprev = w_val[gi];
            end else begin : g_mid_prev
                assign w_prev  = w_flags[gi - 1];
                assign w_vprev = w_val[gi - 1];
            end

            if (gi == CAPACITY - 1) begin : g_last
                assign w_next  = '{lt: 1'b0, le: 1'b0, gt: 1'b0};
                assign w_vnext = w_val[gi];
            end else begin : g_mid_next
                assign w_next  = w_flags[gi + 1];
                assign w_vnext = w_val[gi + 1];
            end

            osm_cell u_cell (
                .i_clk      (i_clk),
                .i_index    (IDX_W'(gi)),
                .i_bc       (w_bc),
                .i_prev     (w_prev),
                .i_next     (w_next),
                .i_val_prev (w_vprev),
                .i_val_next (w_vnext),
                .o_flags    (w_flags[gi]),
                .o_value    (w_val[gi]),
                .o_hit      (w_hits[gi])
            );
        end
    endgenerate

    osm_reduce u_reduce (
        .i_clk  (i_clk),
        .i_hits (w_hits),
        .o_red  (w_red)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_valid <= n_valid;
        end
        r_op     <= n_op;
        r_value  <= n_value;
        r_result <= n_result;
        r_status <= n_status;
    end

    always_comb begin
        busy     = (r_state != S_IDLE) && (r_state != S_FIN);
        w_accept = start && !busy;
        w_pos    = w_red.hit ? CNT_W'(w_red.idx) : CNT_W'(CAPACITY);

        n_state  = r_state;
        n_op     = r_op;
        n_value  = r_value;
        n_count  = r_count;
        n_valid  = 1'b0;
        n_result = '0;
        n_status = ST_OK;

        w_bc.cmp_en  = (r_state == S_CMP);
        w_bc.ins_en  = 1'b0;
        w_bc.del_en  = 1'b0;
        w_bc.op      = r_op;
        w_bc.value   = r_value;
        w_bc.sel_idx = IDX_W'(r_value[IDX_W-1:0] - IDX_W'(1));
        w_bc.count   = r_count;

        case (r_state)
            S_IDLE:  n_state = S_IDLE;
            S_CMP:   n_state = S_RED1;
            S_RED1:  n_state = S_RED2;
            S_RED2:  n_state = S_FIN;
            S_FIN: begin
                n_state = S_IDLE;
                n_valid = 1'b1;
                case (r_op)
                    OP_INS: begin
                        if (r_count == CNT_W'(CAPACITY)) begin
                            n_status = ST_FULL;
                        end else begin
                            w_bc.ins_en = 1'b1;
                            n_count     = r_count + CNT_W'(1);
                        end
                    end
                    OP_DEL: begin
                        if (w_red.hit) begin
                            w_bc.del_en = 1'b1;
                            n_count     = r_count - CNT_W'(1);
                        end else begin
                            n_status = ST_MISSING;
                        end
                    end
                    OP_RANK: begin
                        n_result = $signed(DATA_W'(w_pos) + DATA_W'(1));
                    end
                    OP_SEL: begin
                        if (!r_value[DATA_W-1] && (r_value != '0)
                                && ($unsigned(r_value) <= DATA_W'(r_count))) begin
                            n_result = $signed(w_red.value);
                        end else begin
                            n_status = ST_MISSING;
                        end
                    end
                    OP_PRED, OP_SUCC: begin
                        if (w_red.hit) begin
                            n_result = $signed(w_red.value);
                        end else begin
                            n_status = ST_MISSING;
                        end
                    end
                    default: n_result = '0;
                endcase
            end
            default: n_state = S_IDLE;
        endcase

        if (w_accept) begin
            n_state = S_CMP;
            n_op    = t_op'(i_operation);
            n_value = i_operand_value;
        end
    end

    assign o_valid        = r_valid;
    assign o_result_value = r_result;
    assign o_status       = r_status;

    `OSM_ASSERT(a_count_bound, r_count <= CNT_W'(CAPACITY))
    `OSM_ASSERT(a_no_overfill, !(w_bc.ins_en && (r_count == CNT_W'(CAPACITY))))
    `OSM_ASSERT_NEXT(a_fin_strobe, r_state == S_FIN, o_valid)
    `OSM_ASSERT_NEXT(a_accept_cmp, start && !busy, r_state == S_CMP)
    `OSM_ASSERT_NEXT(a_del_count, w_bc.del_en, r_count == $past(r_count) - CNT_W'(1))

endmodule

`default_nettype wire

[tb/sv/tb_order_statistic_multiset.sv]
`timescale 1ns / 1ps

module tb_order_statistic_multiset
    import osm_pkg::*;
();

    localparam logic [2:0] OP_RSVD6 = 3'd6;
    localparam logic [2:0] OP_RSVD7 = 3'd7;
    localparam logic signed [DATA_W-1:0] VAL_MIN = 32'sh8000_0000;
    localparam logic signed [DATA_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;
    localparam int STALL_LIMIT = 4000;
    localparam int SCRIPT_LEN = 26;

    typedef struct {
        logic signed [DATA_W-1:0] value;
        t_status                  status;
    } t_reply;

    typedef struct {
        logic [2:0]               op;
        logic signed [DATA_W-1:0] operand;
        bit                       pinned;
        logic signed [DATA_W-1:0] value;
        t_status                  status;
    } t_script_row;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     start = 1'b0;
    logic                     busy;
    logic [2:0]               i_operation = '0;
    logic signed [DATA_W-1:0] i_operand_value = '0;
    logic                     o_valid;
    logic signed [DATA_W-1:0] o_result_value;
    logic [1:0]               o_status;

    logic signed [DATA_W-1:0] multiset_vals [CAPACITY];
    int                       multiset_size = 0;
    t_reply                   pending_replies [$];

    int  error_total = 0;
    int  commands_issued = 0;
    int  replies_checked = 0;
    int  full_replies = 0;
    int  missing_replies = 0;
    int  stall_cycles = 0;
    bit  gaps_enabled = 1'b1;

    t_script_row script_rows [SCRIPT_LEN] = '{
        '{OP_RANK,  0,       1'b1, 1, ST_OK},
        '{OP_SEL,   1,       1'b1, 0, ST_MISSING},
        '{OP_PRED,  0,       1'b1, 0, ST_MISSING},
        '{OP_SUCC,  0,       1'b1, 0, ST_MISSING},
        '{OP_DEL,   5,       1'b1, 0, ST_MISSING},
        '{OP_INS,   VAL_MIN, 1'b1, 0, ST_OK},
        '{OP_INS,   VAL_MAX, 1'b1, 0, ST_OK},
        '{OP_INS,   0,       1'b1, 0, ST_OK},
        '{OP_INS,   0,       1'b1, 0, ST_OK},
        '{OP_INS,   -1,      1'b1, 0, ST_OK},
        '{OP_PRED,  VAL_MIN, 1'b1, 0, ST_MISSING},
        '{OP_SUCC,  VAL_MAX, 1'b1, 0, ST_MISSING},
        '{OP_PRED,  VAL_MAX, 1'b0, 0, ST_OK},
        '{OP_SUCC,  VAL_MIN, 1'b0, 0, ST_OK},
        '{OP_RANK,  VAL_MAX, 1'b0, 0, ST_OK},
        '{OP_RANK,  VAL_MIN, 1'b1, 1, ST_OK},
        '{OP_SEL,   0,       1'b1, 0, ST_MISSING},
        '{OP_SEL,   -1,      1'b1, 0, ST_MISSING},
        '{OP_SEL,   VAL_MAX, 1'b1, 0, ST_MISSING},
        '{OP_SEL,   1,       1'b0, 0, ST_OK},
        '{OP_SEL,   5,       1'b0, 0, ST_OK},
        '{OP_DEL,   0,       1'b1, 0, ST_OK},
        '{OP_DEL,   7,       1'b1, 0, ST_MISSING},
        '{OP_RSVD6, VAL_MAX, 1'b1, 0, ST_OK},
        '{OP_RSVD7, -1,      1'b1, 0, ST_OK},
        '{OP_SUCC,  -1,      1'b0, 0, ST_OK}
    };

    order_statistic_multiset dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_operation     (i_operation),
        .i_operand_value (i_operand_value),
        .o_valid         (o_valid),
        .o_result_value  (o_result_value),
        .o_status        (o_status)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic int count_below(input logic signed [DATA_W-1:0] v);
        int n;
        n = 0;
        for (int i = 0; i < multiset_size; i++) begin
            if (multiset_vals[i] < v) n++;
        end
        return n;
    endfunction

    function automatic int count_at_or_below(input logic signed [DATA_W-1:0] v);
        int n;
        n = 0;
        for (int i = 0; i < multiset_size; i++) begin
            if (multiset_vals[i] <= v) n++;
        end
        return n;
    endfunction

    // Applies one transaction to the shadow multiset and returns its reply.
    function automatic t_reply compute_reply(input logic [2:0] op,
                                             input logic signed [DATA_W-1:0] v);
        t_reply r;
        int     pos;
        r.value = '0;
        r.status = ST_OK;
        case (op)
            OP_INS: begin
                if (multiset_size >= CAPACITY) begin
                    r.status = ST_FULL;
                end else begin
                    pos = count_at_or_below(v);
                    for (int i = multiset_size; i > pos; i--) begin
                        multiset_vals[i] = multiset_vals[i-1];
                    end
                    multiset_vals[pos] = v;
                    multiset_size++;
                end
            end
            OP_DEL: begin
                pos = count_below(v);
                if (pos >= multiset_size || multiset_vals[pos] != v) begin
                    r.status = ST_MISSING;
                end else begin
                    for (int i = pos; i + 1 < multiset_size; i++) begin
                        multiset_vals[i] = multiset_vals[i+1];
                    end
                    multiset_size--;
                end
            end
            OP_RANK: r.value = count_below(v) + 1;
            OP_SEL: begin
                if (v < 1 || v > multiset_size) r.status = ST_MISSING;
                else r.value = multiset_vals[v-1];
            end
            OP_PRED: begin
                pos = count_below(v);
                if (pos == 0) r.status = ST_MISSING;
                else r.value = multiset_vals[pos-1];
            end
            OP_SUCC: begin
                pos = count_at_or_below(v);
                if (pos >= multiset_size) r.status = ST_MISSING;
                else r.value = multiset_vals[pos];
            end
            default: ;
        endcase
        return r;
    endfunction

    function automatic logic [2:0] choose_op(input int ins_pct, input int del_pct);
        int r;
        r = $urandom_range(0, 99);
        if (r < ins_pct) return OP_INS;
        if (r < ins_pct + del_pct) return OP_DEL;
        case ($urandom_range(0, 16))
            0, 1, 2, 3: return OP_RANK;
            4, 5, 6, 7: return OP_SEL;
            8, 9, 10, 11: return OP_PRED;
            12, 13, 14, 15: return OP_SUCC;
            default: return $urandom_range(0, 1) ? OP_RSVD6 : OP_RSVD7;
        endcase
    endfunction

    function automatic logic signed [DATA_W-1:0] choose_operand(input logic [2:0] op);
        int r;
        r = $urandom_range(0, 99);
        if (op == OP_SEL && r < 70) return $urandom_range(0, multiset_size + 1);
        if (r < 20) return int'($urandom_range(0, 16)) - 8;
        if (r < 30) begin
            case ($urandom_range(0, 5))
                0: return VAL_MIN;
                1: return VAL_MIN + 1;
                2: return VAL_MAX;
                3: return VAL_MAX - 1;
                4: return 0;
                default: return -1;
            endcase
        end
        if (r < 65 && multiset_size > 0) begin
            return multiset_vals[$urandom_range(0, multiset_size - 1)]
                   + (int'($urandom_range(0, 2)) - 1);
        end
        return $urandom;
    endfunction

    task automatic issue_command(input logic [2:0] op,
                                 input logic signed [DATA_W-1:0] arg,
                                 input bit pinned,
                                 input t_reply pinned_reply);
        t_reply predicted;
        @(negedge i_clk);
        start <= 1'b1;
        i_operation <= op;
        i_operand_value <= arg;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        predicted = compute_reply(op, arg);
        pending_replies.push_back(pinned ? pinned_reply : predicted);
        commands_issued++;
    endtask

    task automatic random_command(input int ins_pct, input int del_pct);
        logic [2:0]               op;
        logic signed [DATA_W-1:0] arg;
        t_reply                   unused;
        if (gaps_enabled && $urandom_range(0, 99) < 10) begin
            @(negedge i_clk);
            start <= 1'b0;
            repeat ($urandom_range(0, 5)) @(negedge i_clk);
        end
        op = choose_op(ins_pct, del_pct);
        arg = choose_operand(op);
        unused = '{0, ST_OK};
        issue_command(op, arg, 1'b0, unused);
    endtask

    always @(posedge i_clk) begin
        t_reply want;
        if (i_rst_n) begin
            if ((start && !busy) || o_valid) stall_cycles = 0;
            else stall_cycles++;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("[FAIL] regression broken");
                $finish;
            end
            if (o_valid) begin
                if (pending_replies.size() == 0) begin
                    $error("unexpected result: value %0d status %0d",
                           o_result_value, o_status);
                    error_total++;
                end else begin
                    want = pending_replies.pop_front();
                    replies_checked++;
                    if (want.status == ST_FULL) full_replies++;
                    if (want.status == ST_MISSING) missing_replies++;
                    if (o_result_value !== want.value) begin
                        $error("result_value: expected %0d, got %0d",
                               want.value, o_result_value);
                        error_total++;
                    end
                    if (o_status !== want.status) begin
                        $error("status: expected %0d, got %0d",
                               want.status, o_status);
                        error_total++;
                    end
                end
            end
        end
    end

    initial begin
        t_reply typed;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (int k = 0; k < SCRIPT_LEN; k++) begin
            typed = '{script_rows[k].value, script_rows[k].status};
            issue_command(script_rows[k].op, script_rows[k].operand,
                          script_rows[k].pinned, typed);
        end

        repeat (400) random_command(25, 15);

        // Hold the command side off until every outstanding transaction has returned.
        @(negedge i_clk);
        start <= 1'b0;
        while (pending_replies.size() != 0) @(posedge i_clk);

        // Fill the store back to back, then hammer it while full.
        gaps_enabled = 1'b0;
        while (multiset_size < CAPACITY) random_command(85, 0);
        gaps_enabled = 1'b1;
        repeat (80) random_command(60, 10);

        repeat (250) random_command(10, 60);
        repeat (150) random_command(30, 30);

        @(negedge i_clk);
        start <= 1'b0;
        while (pending_replies.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        $display("Sent %0d commands and checked %0d results.",
                 commands_issued, replies_checked);
        $display("Saw %0d inserts into a full store and %0d not-found replies.",
                 full_replies, missing_replies);
        if (error_total == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
